@@ sv/gli_pkg.sv @@
// shared types and constants of the gap limited time interpolator
`default_nettype none
package gli_pkg;
   localparam int DEPTH_DEF = 256;
   localparam logic [15:0] GAP_RESET = 16'd180;
   localparam logic signed [31:0] HUNDRED_Q = 32'sd6553600;

   localparam logic [1:0] OP_LOAD  = 2'd0;
   localparam logic [1:0] OP_QUERY = 2'd1;
   localparam logic [1:0] OP_CLEAR = 2'd2;

   localparam logic [1:0] ST_VALID   = 2'd0;
   localparam logic [1:0] ST_MISSING = 2'd1;
   localparam logic [1:0] ST_SKIPPED = 2'd2;

   localparam logic [1:0] CLAMP_RANGE = 2'd1;
   localparam logic [1:0] CLAMP_DROP  = 2'd2;

   localparam logic [2:0] REG_MAX_GAP   = 3'd0;
   localparam logic [2:0] REG_WIN_START = 3'd1;
   localparam logic [2:0] REG_WIN_END   = 3'd2;
   localparam logic [2:0] REG_OBS_MODE  = 3'd3;
   localparam logic [2:0] REG_WALL      = 3'd4;
   localparam logic [2:0] REG_INTERP    = 3'd5;
   localparam logic [2:0] REG_CLAMP     = 3'd6;

   localparam int NUM_W = 48;

   typedef struct packed {
      logic [31:0]        t;
      logic signed [31:0] v;
      logic               miss;
   } entry_type;
endpackage
`default_nettype wire

@@ sv/gli_mem.sv @@
// sample store: one write port, one registered read port
`default_nettype none
module gli_mem import gli_pkg::*; #(
   parameter int DEPTH = DEPTH_DEF
) (
   input  wire logic                     clock,
   input  wire logic                     wr_en,
   input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
   input  wire entry_type                wr_data,
   input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
   output entry_type                     rd_data
);
   entry_type mem [DEPTH];
   entry_type rd_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_ff <= mem[rd_addr];
   end

   assign rd_data = rd_ff;
endmodule
`default_nettype wire

@@ sv/gli_div.sv @@
// restoring divider, one quotient bit per cycle
`default_nettype none
module gli_div import gli_pkg::*; (
   input  wire logic               clock,
   input  wire logic               reset,
   input  wire logic               start,
   input  wire logic [NUM_W-1:0]   dividend,
   input  wire logic [15:0]        divisor,
   output logic                    done,
   output logic [NUM_W-1:0]        quotient
);
   localparam int CNT_W = $clog2(NUM_W);

   logic [NUM_W-1:0] dvd_ff, dvd_in;
   logic [15:0]      rem_ff, rem_in, div_ff;
   logic [CNT_W-1:0] cnt_ff, cnt_in;
   logic             busy_ff, busy_in, done_ff, done_in;
   logic [16:0]      trial;

   always_comb begin
      dvd_in  = dvd_ff;
      rem_in  = rem_ff;
      cnt_in  = cnt_ff;
      busy_in = busy_ff;
      done_in = 1'b0;
      trial   = {rem_ff, dvd_ff[NUM_W-1]};
      if (start) begin
         dvd_in  = dividend;
         rem_in  = '0;
         cnt_in  = '0;
         busy_in = 1'b1;
      end else if (busy_ff) begin
         if (trial >= {1'b0, div_ff}) begin
            rem_in = 16'(trial - {1'b0, div_ff});
            dvd_in = {dvd_ff[NUM_W-2:0], 1'b1};
         end else begin
            rem_in = trial[15:0];
            dvd_in = {dvd_ff[NUM_W-2:0], 1'b0};
         end
         cnt_in = cnt_ff + 1'b1;
         if (cnt_ff == CNT_W'(NUM_W - 1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
      dvd_ff <= dvd_in;
      rem_ff <= rem_in;
      cnt_ff <= cnt_in;
      if (start) begin
         div_ff <= divisor;
      end
   end

   assign done     = done_ff;
   assign quotient = dvd_ff;
endmodule
`default_nettype wire

@@ sv/gap_limited_time_interpolator.sv @@
// Gap limited time interpolator: resamples one time-sorted series of Q16.16 samples.
// Request channel (req_*): opcode 0 appends a sample, 1 queries a time key,
// 2 empties the store. Only queries give a transaction on the response
// channel (rsp_*): a value and a status (valid, missing or skipped).
// Loads and clears complete without leaving idle. A query reads the store one
// entry at a time through the registered read port: the cursor walk from the
// last found position, then, in linear mode, the outward scan to valid
// neighbours. Linear interpolation adds two multiply steps (S_MUL1, S_MUL2)
// and a restoring division of the weighted sum by the gap, one quotient bit
// at a time.
// One query is in flight at a time; requests wait while it runs.
// A finished response sits in the output register; if the receiver stalls,
// the next request is still taken, and a following query holds at its end
// until the register frees.
// Reset empties the store, zeroes the cursor and returns the registers to
// their defaults; store contents are not cleared. Registers sit on the
// csr_ port at byte address 4 * index; reads return only their implemented bits.
`default_nettype none
module gap_limited_time_interpolator import gli_pkg::*; #(
   parameter int DEPTH = DEPTH_DEF
) (
   input  wire logic               clock,
   input  wire logic               reset,
   input  wire logic               req_valid,
   output logic                    req_ready,
   input  wire logic [1:0]         req_opcode,
   input  wire logic [31:0]        req_time_key,
   input  wire logic signed [31:0] req_sample_value,
   input  wire logic               req_sample_missing,
   output logic                    rsp_valid,
   input  wire logic               rsp_ready,
   output logic signed [31:0]      rsp_value_out,
   output logic [1:0]              rsp_status,
   input  wire logic               csr_psel,
   input  wire logic               csr_penable,
   input  wire logic               csr_pwrite,
   input  wire logic [4:0]         csr_paddr,
   input  wire logic [31:0]        csr_pwdata,
   output logic [31:0]             csr_prdata,
   output logic                    csr_pready
);
   localparam int AW = $clog2(DEPTH);
   localparam int CW = $clog2(DEPTH + 1);

   localparam logic [3:0] S_IDLE  = 4'd0;
   localparam logic [3:0] S_BACK  = 4'd1;
   localparam logic [3:0] S_BACKW = 4'd2;
   localparam logic [3:0] S_FWD   = 4'd3;
   localparam logic [3:0] S_FWDW  = 4'd4;
   localparam logic [3:0] S_NXT   = 4'd5;
   localparam logic [3:0] S_NXTW  = 4'd6;
   localparam logic [3:0] S_PRV   = 4'd7;
   localparam logic [3:0] S_PRVW  = 4'd8;
   localparam logic [3:0] S_GAP   = 4'd9;
   localparam logic [3:0] S_MUL1  = 4'd10;
   localparam logic [3:0] S_MUL2  = 4'd11;
   localparam logic [3:0] S_DIVS  = 4'd12;
   localparam logic [3:0] S_DIVW  = 4'd13;
   localparam logic [3:0] S_CLAMP = 4'd14;
   localparam logic [3:0] S_OUT   = 4'd15;

   // configuration registers
   logic [15:0] max_gap_ff;
   logic [31:0] win_start_ff, win_end_ff, wall_ff;
   logic        obs_ff, interp_ff;
   logic [1:0]  clamp_ff;
   logic [2:0]  csr_idx;
   logic        csr_wr;

   assign csr_idx    = csr_paddr[4:2];
   assign csr_wr     = csr_psel && csr_penable && csr_pwrite;
   assign csr_pready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         max_gap_ff   <= GAP_RESET;
         win_start_ff <= '0;
         win_end_ff   <= '1;
         obs_ff       <= 1'b0;
         wall_ff      <= '1;
         interp_ff    <= 1'b0;
         clamp_ff     <= '0;
      end else if (csr_wr) begin
         case (csr_idx)
            REG_MAX_GAP:   max_gap_ff   <= csr_pwdata[15:0];
            REG_WIN_START: win_start_ff <= csr_pwdata;
            REG_WIN_END:   win_end_ff   <= csr_pwdata;
            REG_OBS_MODE:  obs_ff       <= csr_pwdata[0];
            REG_WALL:      wall_ff      <= csr_pwdata;
            REG_INTERP:    interp_ff    <= csr_pwdata[0];
            REG_CLAMP:     clamp_ff     <= csr_pwdata[1:0];
            default: ;
         endcase
      end
   end

   always_comb begin
      case (csr_idx)
         REG_MAX_GAP:   csr_prdata = {16'd0, max_gap_ff};
         REG_WIN_START: csr_prdata = win_start_ff;
         REG_WIN_END:   csr_prdata = win_end_ff;
         REG_OBS_MODE:  csr_prdata = {31'd0, obs_ff};
         REG_WALL:      csr_prdata = wall_ff;
         REG_INTERP:    csr_prdata = {31'd0, interp_ff};
         REG_CLAMP:     csr_prdata = {30'd0, clamp_ff};
         default:       csr_prdata = '0;
      endcase
   end

   // sequencer state
   logic [3:0]  state_ff, state_in;
   logic [CW-1:0] count_ff, count_in, cursor_ff, cursor_in;
   logic [CW-1:0] pos_ff, pos_in, ptr_ff, ptr_in;
   logic [31:0] q_ff, q_in;
   entry_type   e1_ff, e1_in, e2_ff, e2_in;
   logic [15:0] gap_ff, gap_in, gap1_ff, gap1_in;
   logic signed [49:0] acc_ff, acc_in, prod;
   logic signed [31:0] val_ff, val_in;
   logic [1:0]  st_ff, st_in;
   logic        rsp_valid_ff, rsp_valid_in;
   logic signed [31:0] rsp_value_ff, rsp_value_in;
   logic [1:0]  rsp_status_ff, rsp_status_in;

   logic          mem_we;
   logic [AW-1:0] mem_raddr;
   entry_type     mem_wdata, rd;
   logic          div_start, div_done;
   logic [NUM_W-1:0] dvd_mag, quo;
   logic signed [32:0] gap_w, gap1_w;
   logic signed [33:0] g1, g2, mn;
   logic signed [NUM_W:0] qs;
   logic          accept;

   assign req_ready = (state_ff == S_IDLE);
   assign accept    = req_valid && req_ready;
   assign mem_wdata = '{t: req_time_key, v: req_sample_value, miss: req_sample_missing};
   assign dvd_mag   = acc_ff[49] ? NUM_W'(-acc_ff) : NUM_W'(acc_ff);

   gli_mem #(.DEPTH(DEPTH)) u_mem (
      .clock   (clock),
      .wr_en   (mem_we),
      .wr_addr (count_ff[AW-1:0]),
      .wr_data (mem_wdata),
      .rd_addr (mem_raddr),
      .rd_data (rd)
   );

   gli_div u_div (
      .clock    (clock),
      .reset    (reset),
      .start    (div_start),
      .dividend (dvd_mag),
      .divisor  (gap_ff),
      .done     (div_done),
      .quotient (quo)
   );

   always_comb begin
      state_in      = state_ff;
      count_in      = count_ff;
      cursor_in     = cursor_ff;
      pos_in        = pos_ff;
      ptr_in        = ptr_ff;
      q_in          = q_ff;
      e1_in         = e1_ff;
      e2_in         = e2_ff;
      gap_in        = gap_ff;
      gap1_in       = gap1_ff;
      acc_in        = acc_ff;
      val_in        = val_ff;
      st_in         = st_ff;
      rsp_valid_in  = rsp_valid_ff && !rsp_ready;
      rsp_value_in  = rsp_value_ff;
      rsp_status_in = rsp_status_ff;
      mem_we        = 1'b0;
      mem_raddr     = pos_ff[AW-1:0];
      div_start     = 1'b0;
      prod          = '0;
      gap_w  = $signed({1'b0, e2_ff.t}) - $signed({1'b0, e1_ff.t});
      gap1_w = $signed({1'b0, q_ff}) - $signed({1'b0, e1_ff.t});
      g1     = $signed({2'b0, q_ff}) - $signed({2'b0, e1_ff.t});
      g2     = $signed({2'b0, e2_ff.t}) - $signed({2'b0, q_ff});
      mn     = (g1 < g2) ? g1 : g2;
      qs     = acc_ff[49] ? -$signed({1'b0, quo}) : $signed({1'b0, quo});

      case (state_ff)
         S_IDLE: begin
            if (accept) begin
               case (req_opcode)
                  OP_LOAD: begin
                     if (count_ff < CW'(DEPTH)) begin
                        mem_we   = 1'b1;
                        count_in = count_ff + 1'b1;
                     end
                  end
                  OP_CLEAR: begin
                     count_in  = '0;
                     cursor_in = '0;
                  end
                  OP_QUERY: begin
                     q_in  = req_time_key;
                     st_in = ST_SKIPPED;
                     val_in = '0;
                     if (req_time_key >= win_start_ff && req_time_key <= win_end_ff &&
                         !(obs_ff && req_time_key > wall_ff)) begin
                        pos_in   = (cursor_ff > count_ff) ? count_ff : cursor_ff;
                        state_in = S_BACK;
                     end else begin
                        state_in = S_OUT;
                     end
                  end
                  default: ;
               endcase
            end
         end
         S_BACK: begin
            mem_raddr = AW'(pos_ff - 1'b1);
            state_in  = (pos_ff == '0) ? S_FWD : S_BACKW;
         end
         S_BACKW: begin
            if (rd.t >= q_ff) begin
               pos_in   = pos_ff - 1'b1;
               state_in = S_BACK;
            end else begin
               state_in = S_FWD;
            end
         end
         S_FWD: begin
            mem_raddr = pos_ff[AW-1:0];
            state_in  = (pos_ff >= count_ff) ? S_OUT : S_FWDW;
         end
         S_FWDW: begin
            if (rd.t < q_ff) begin
               pos_in   = pos_ff + 1'b1;
               state_in = S_FWD;
            end else begin
               cursor_in = pos_ff;
               e2_in     = rd;
               ptr_in    = pos_ff - 1'b1;
               if (rd.t == q_ff) begin
                  st_in    = rd.miss ? ST_MISSING : ST_VALID;
                  val_in   = rd.v;
                  state_in = S_CLAMP;
               end else if (pos_ff == '0) begin
                  st_in    = ST_MISSING;
                  state_in = S_OUT;
               end else if (!interp_ff && rd.miss) begin
                  ptr_in   = pos_ff + 1'b1;
                  state_in = S_NXT;
               end else begin
                  state_in = S_PRV;
               end
            end
         end
         // linear mode: scan forward for a valid later sample
         S_NXT: begin
            mem_raddr = ptr_ff[AW-1:0];
            if (ptr_ff >= count_ff) begin
               st_in    = ST_MISSING;
               state_in = S_OUT;
            end else begin
               state_in = S_NXTW;
            end
         end
         S_NXTW: begin
            if (rd.miss) begin
               ptr_in   = ptr_ff + 1'b1;
               state_in = S_NXT;
            end else begin
               e2_in    = rd;
               ptr_in   = pos_ff - 1'b1;
               state_in = S_PRV;
            end
         end
         S_PRV: begin
            mem_raddr = ptr_ff[AW-1:0];
            state_in  = S_PRVW;
         end
         S_PRVW: begin
            e1_in = rd;
            if (interp_ff) begin
               // nearest pick handled once e1 is registered
               state_in = S_GAP;
            end else if (!rd.miss) begin
               state_in = S_GAP;
            end else if (ptr_ff == '0) begin
               st_in    = ST_MISSING;
               state_in = S_OUT;
            end else begin
               ptr_in   = ptr_ff - 1'b1;
               state_in = S_PRV;
            end
         end
         S_GAP: begin
            if (interp_ff) begin
               if (mn > $signed({18'd0, max_gap_ff})) begin
                  st_in    = ST_MISSING;
                  state_in = S_OUT;
               end else if (g1 < g2) begin
                  st_in    = e1_ff.miss ? ST_MISSING : ST_VALID;
                  val_in   = e1_ff.v;
                  state_in = S_CLAMP;
               end else begin
                  st_in    = e2_ff.miss ? ST_MISSING : ST_VALID;
                  val_in   = e2_ff.v;
                  state_in = S_CLAMP;
               end
            end else if (gap_w > $signed({17'd0, max_gap_ff}) || gap_w <= 0 ||
                         gap1_w < 0 || gap1_w > gap_w) begin
               st_in    = ST_MISSING;
               state_in = S_OUT;
            end else begin
               gap_in   = gap_w[15:0];
               gap1_in  = gap1_w[15:0];
               state_in = S_MUL1;
            end
         end
         S_MUL1: begin
            prod     = $signed({1'b0, 16'(gap_ff - gap1_ff)}) * e1_ff.v;
            acc_in   = prod;
            state_in = S_MUL2;
         end
         S_MUL2: begin
            prod     = $signed({1'b0, gap1_ff}) * e2_ff.v;
            acc_in   = acc_ff + prod;
            state_in = S_DIVS;
         end
         S_DIVS: begin
            div_start = 1'b1;
            state_in  = S_DIVW;
         end
         S_DIVW: begin
            if (div_done) begin
               st_in    = ST_VALID;
               val_in   = qs[31:0];
               state_in = S_CLAMP;
            end
         end
         S_CLAMP: begin
            if (st_ff == ST_VALID) begin
               if (clamp_ff == CLAMP_RANGE) begin
                  if (val_ff < 0) begin
                     val_in = '0;
                  end else if (val_ff > HUNDRED_Q) begin
                     val_in = HUNDRED_Q;
                  end
               end else if (clamp_ff == CLAMP_DROP && val_ff > HUNDRED_Q) begin
                  st_in = ST_MISSING;
               end
            end
            state_in = S_OUT;
         end
         S_OUT: begin
            if (!rsp_valid_ff || rsp_ready) begin
               rsp_valid_in  = 1'b1;
               rsp_status_in = st_ff;
               rsp_value_in  = (st_ff == ST_VALID) ? val_ff : '0;
               state_in      = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         count_ff     <= '0;
         cursor_ff    <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         count_ff     <= count_in;
         cursor_ff    <= cursor_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      pos_ff        <= pos_in;
      ptr_ff        <= ptr_in;
      q_ff          <= q_in;
      e1_ff         <= e1_in;
      e2_ff         <= e2_in;
      gap_ff        <= gap_in;
      gap1_ff       <= gap1_in;
      acc_ff        <= acc_in;
      val_ff        <= val_in;
      st_ff         <= st_in;
      rsp_value_ff  <= rsp_value_in;
      rsp_status_ff <= rsp_status_in;
   end

   assign rsp_valid     = rsp_valid_ff;
   assign rsp_value_out = rsp_value_ff;
   assign rsp_status    = rsp_status_ff;
endmodule
`default_nettype wire
